@@ rtl/core/ttml_pkg.sv @@
`default_nettype none
package ttml_pkg;

    typedef enum logic [0:0] {
        MDU_MUL,
        MDU_DIV
    } t_mdu_op;

    typedef struct packed {
        logic    start;
        t_mdu_op op;
    } t_mdu_req;

    typedef enum logic [4:0] {
        S_IDLE,
        S_SQRT,
        S_SQRT_END,
        S_WAIT,
        S_Q10,
        S_DEN1,
        S_R1NUM,
        S_R1,
        S_EXP_INIT,
        S_EXP_T,
        S_EXP_K,
        S_EXP_P,
        S_EXP_PM,
        S_EXP_DONE,
        S_EULER,
        S_EUL_D,
        S_EUL_N,
        S_POW,
        S_R2NUM,
        S_R2,
        S_FIN1,
        S_FIN2,
        S_FIN3
    } t_state;

    localparam logic [63:0] ONE_Q30    = 64'd1 << 30;
    localparam logic [63:0] D_CAP      = 64'd1 << 62;
    localparam logic [63:0] W24        = 64'hFF_FFFF;
    localparam logic [63:0] KV1_Q30    = ((64'd2113 << 30) + 64'd5000) / 64'd10000;
    localparam logic [63:0] KV2_Q30    = ((64'd4336 << 30) + 64'd5000) / 64'd10000;
    localparam logic [63:0] TG2_Q24    = ((64'd42687 << 24) + 64'd5000) / 64'd10000;
    localparam logic [63:0] TWO_PI_Q24 =
        (64'd6283185307 * 64'd16777216 + 64'd500000000) / 64'd1000000000;
    localparam logic [63:0] KK1        = (KV1_Q30 * KV1_Q30) >> 30;
    localparam logic [63:0] KV2SQ      = (KV2_Q30 * KV2_Q30) >> 30;
    localparam logic [63:0] KV3        = (KV2SQ * KV2_Q30) >> 30;
    localparam logic [63:0] KV6        = (KV3 * KV3) >> 30;
    localparam logic [63:0] TG2SQ      = (TG2_Q24 * TG2_Q24) >> 24;
    localparam logic [63:0] CNUM       = (TG2SQ * KV6) >> 24;
    localparam logic [63:0] CQ         = (CNUM << 24) / TWO_PI_Q24;

    // e^-1, e^-2, e^-4, e^-8, e^-16 in Q30, each the floor square of the last
    localparam logic [63:0] EXP_P0 = 64'd395007542;
    localparam logic [63:0] EXP_P1 = (EXP_P0 * EXP_P0) >> 30;
    localparam logic [63:0] EXP_P2 = (EXP_P1 * EXP_P1) >> 30;
    localparam logic [63:0] EXP_P3 = (EXP_P2 * EXP_P2) >> 30;
    localparam logic [63:0] EXP_P4 = (EXP_P3 * EXP_P3) >> 30;

    localparam int EXP_TERMS = 14;
    localparam int EXP_BITS  = 5;
    localparam int POW_MULS  = 4;

    function automatic logic [63:0] exp_factor(input logic [2:0] idx);
        logic [63:0] f;
        case (idx)
            3'd0:    f = EXP_P0;
            3'd1:    f = EXP_P1;
            3'd2:    f = EXP_P2;
            3'd3:    f = EXP_P3;
            3'd4:    f = EXP_P4;
            default: f = 64'd0;
        endcase
        return f;
    endfunction

endpackage
`default_nettype wire

@@ rtl/core/ttml_mdu.sv @@
`default_nettype none
// Shared bit-serial unit: 64x32 multiply and 64/64 divide.
module ttml_mdu (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire ttml_pkg::t_mdu_req i_req,
    input  wire logic [63:0]       i_a,
    input  wire logic [63:0]       i_b,
    output logic                   o_done,
    output logic [95:0]            o_res
);
    import ttml_pkg::*;

    logic        r_busy;
    logic        r_done;
    t_mdu_op     r_op;
    logic [5:0]  r_cnt;
    logic [95:0] r_acc;
    logic [95:0] r_mc;
    logic [31:0] r_mp;
    logic [64:0] r_rem;
    logic [63:0] r_nq;
    logic [63:0] r_den;

    logic [64:0] w_rem_sh;
    logic        w_ge;
    logic        w_last;

    assign w_rem_sh = {r_rem[63:0], r_nq[63]};
    assign w_ge     = (w_rem_sh >= {1'b0, r_den});
    assign w_last   = (r_op == MDU_DIV) ? (r_cnt == 6'd63) : (r_cnt == 6'd31);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_op   <= MDU_MUL;
            r_cnt  <= 6'd0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_op   <= i_req.op;
                r_cnt  <= 6'd0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 6'd1;
                if (w_last) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_acc <= 96'd0;
            r_mc  <= {32'd0, i_a};
            r_mp  <= i_b[31:0];
            r_rem <= 65'd0;
            r_nq  <= i_a;
            r_den <= i_b;
        end else if (r_busy) begin
            if (r_op == MDU_MUL) begin
                if (r_mp[0]) begin
                    r_acc <= r_acc + r_mc;
                end
                r_mc <= {r_mc[94:0], 1'b0};
                r_mp <= {1'b0, r_mp[31:1]};
            end else begin
                // restoring step: numerator shifts out the top, quotient fills the bottom
                if (w_ge) begin
                    r_rem <= w_rem_sh - {1'b0, r_den};
                end else begin
                    r_rem <= w_rem_sh;
                end
                r_nq <= {r_nq[62:0], w_ge};
            end
        end
    end

    assign o_done = r_done;
    assign o_res  = (r_op == MDU_DIV) ? {32'd0, r_nq} : r_acc;

endmodule
`default_nettype wire

@@ rtl/core/two_tank_model_linearizer_core.sv @@
// Work runs on one shared bit-serial mul/div. The shortest path (empty tank or full tank, zero outflow)
// skips both poles; the longest evaluates both poles and applies every exp factor.
// Each exponential takes 14 multiplies and 14 divides; every transaction also runs a 32-step sqrt.
// A new transaction is accepted only once the last has finished; a result may wait in the output register
// while the next transaction is accepted.
// Reset (synchronous, active low): level cleared to 0, sample_time set to 6554.
`default_nettype none
module two_tank_model_linearizer_core #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [23:0] i_cfg_wdata,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [23:0] i_inflow,
    input  wire logic [23:0] i_outflow,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic signed [31:0] o_coef_b0,
    output logic signed [31:0] o_coef_a1,
    output logic signed [31:0] o_coef_a2,
    output logic [1:0]       o_model_delay,
    output logic             o_tank_full
);
    import ttml_pkg::*;

    localparam logic [63:0] A1_F  = ((64'd7329 << FRAC_BITS) + 64'd5000) / 64'd10000;
    localparam logic [63:0] H1_F  = ((64'd46526 << FRAC_BITS) + 64'd5000) / 64'd10000;
    localparam logic [63:0] H_CAP = (H1_F < W24) ? H1_F : W24;

    t_state      r_state, n_state;
    t_state      r_ret, n_ret;
    logic [23:0] r_ts;
    logic [23:0] r_level, n_level;
    logic [23:0] r_u, n_u;
    logic [23:0] r_y, n_y;
    logic [23:0] r_h, n_h;
    logic [63:0] r_srem, n_srem;
    logic [63:0] r_root, n_root;
    logic [63:0] r_sbit, n_sbit;
    logic [4:0]  r_cnt, n_cnt;
    logic [31:0] r_q10, n_q10;
    logic        r_full, n_full;
    logic [63:0] r_den1, n_den1;
    logic [30:0] r_e1, n_e1;
    logic [30:0] r_e2, n_e2;
    logic [63:0] r_d, n_d;
    logic        r_up, n_up;
    logic        r_xsel, n_xsel;
    logic [63:0] r_xr, n_xr;
    logic [4:0]  r_xn, n_xn;
    logic [29:0] r_xf, n_xf;
    logic signed [33:0] r_sum, n_sum;
    logic [3:0]  r_k, n_k;
    logic [2:0]  r_j, n_j;
    logic [30:0] r_xres, n_xres;
    logic [31:0] r_b0, n_b0;
    logic        r_out_valid, n_out_valid;
    logic [31:0] r_ob0, n_ob0;
    logic [31:0] r_oa1, n_oa1;
    logic [31:0] r_oa2, n_oa2;
    logic        r_ofull, n_ofull;

    t_mdu_req    w_req;
    logic [63:0] w_a;
    logic [63:0] w_b;
    logic        w_done;
    logic [95:0] w_res;

    logic [63:0] w_rb;
    logic [95:0] w_shf;
    logic [63:0] w_dn;
    logic [30:0] w_term;
    logic signed [33:0] w_sum;
    logic [31:0] w_diff;
    logic [64:0] w_nh;
    logic [63:0] w_delta;
    logic [30:0] w_b10;
    logic [30:0] w_b20;

    ttml_mdu u_mdu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .i_a     (w_a),
        .i_b     (w_b),
        .o_done  (w_done),
        .o_res   (w_res)
    );

    assign w_rb    = r_root + r_sbit;
    assign w_shf   = w_res >> FRAC_BITS;
    assign w_dn    = (w_shf > {32'd0, D_CAP}) ? D_CAP : w_shf[63:0];
    assign w_term  = w_res[30:0];
    assign w_sum   = r_k[0] ? (r_sum - $signed({3'd0, w_term})) : (r_sum + $signed({3'd0, w_term}));
    assign w_diff  = ({8'd0, r_u} >= r_q10) ? ({8'd0, r_u} - r_q10) : (r_q10 - {8'd0, r_u});
    assign w_delta = w_res[63:0];
    assign w_b10   = ONE_Q30[30:0] - r_e1;
    assign w_b20   = ONE_Q30[30:0] - r_e2;

    always_comb begin
        n_state = r_state;  n_ret = r_ret;   n_level = r_level;
        n_u = r_u;          n_y = r_y;       n_h = r_h;
        n_srem = r_srem;    n_root = r_root; n_sbit = r_sbit;  n_cnt = r_cnt;
        n_q10 = r_q10;      n_full = r_full; n_den1 = r_den1;
        n_e1 = r_e1;        n_e2 = r_e2;     n_d = r_d;        n_up = r_up;
        n_xsel = r_xsel;    n_xr = r_xr;     n_xn = r_xn;      n_xf = r_xf;
        n_sum = r_sum;      n_k = r_k;       n_j = r_j;        n_xres = r_xres;
        n_b0 = r_b0;
        n_ob0 = r_ob0;      n_oa1 = r_oa1;   n_oa2 = r_oa2;    n_ofull = r_ofull;
        n_out_valid = r_out_valid && i_out_stall;
        w_req.start = 1'b0;
        w_req.op    = MDU_MUL;
        w_a = 64'd0;
        w_b = 64'd0;
        w_nh = 65'd0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_u    = i_inflow;
                    n_y    = i_outflow;
                    n_h    = r_level;
                    n_e1   = 31'd0;
                    n_e2   = 31'd0;
                    n_srem = {40'd0, r_level} << FRAC_BITS;
                    n_root = 64'd0;
                    n_sbit = 64'd1 << 62;
                    n_cnt  = 5'd0;
                    n_state = S_SQRT;
                end
            end
            S_SQRT: begin
                if (r_srem >= w_rb) begin
                    n_srem = r_srem - w_rb;
                    n_root = {1'b0, r_root[63:1]} + r_sbit;
                end else begin
                    n_root = {1'b0, r_root[63:1]};
                end
                n_sbit = {2'd0, r_sbit[63:2]};
                n_cnt  = r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    n_state = S_SQRT_END;
                end
            end
            S_SQRT_END: begin
                w_req.start = 1'b1;
                w_a = r_root;
                w_b = KV1_Q30;
                n_ret = S_Q10;
                n_state = S_WAIT;
            end
            S_WAIT: begin
                if (w_done) begin
                    n_state = r_ret;
                end
            end
            S_Q10: begin
                n_q10  = w_res[61:30];
                n_full = ({40'd0, r_h} >= H1_F);
                w_req.start = 1'b1;
                w_a = {32'd0, w_res[61:30]};
                w_b = A1_F;
                n_ret = S_DEN1;
                n_state = S_WAIT;
            end
            S_DEN1: begin
                n_den1 = {w_shf[62:0], 1'b0};
                if (!r_full && ({w_shf[62:0], 1'b0} != 64'd0)) begin
                    w_req.start = 1'b1;
                    w_a = KK1;
                    w_b = {40'd0, r_ts};
                    n_ret = S_R1NUM;
                    n_state = S_WAIT;
                end else begin
                    n_state = S_EULER;
                end
            end
            S_R1NUM: begin
                w_req.start = 1'b1;
                w_req.op = MDU_DIV;
                w_a = w_res[63:0];
                w_b = r_den1;
                n_ret = S_R1;
                n_state = S_WAIT;
            end
            S_R1: begin
                n_xr = w_res[63:0];
                n_xsel = 1'b0;
                n_state = S_EXP_INIT;
            end
            S_EXP_INIT: begin
                if (r_xr[63:35] != 29'd0) begin
                    n_xres = 31'd0;
                    n_state = S_EXP_DONE;
                end else begin
                    n_xn  = r_xr[34:30];
                    n_xf  = r_xr[29:0];
                    n_sum = $signed({3'd0, ONE_Q30[30:0]});
                    n_k   = 4'd1;
                    w_req.start = 1'b1;
                    w_a = ONE_Q30;
                    w_b = {34'd0, r_xr[29:0]};
                    n_ret = S_EXP_T;
                    n_state = S_WAIT;
                end
            end
            S_EXP_T: begin
                w_req.start = 1'b1;
                w_req.op = MDU_DIV;
                w_a = w_res[93:30];
                w_b = {60'd0, r_k};
                n_ret = S_EXP_K;
                n_state = S_WAIT;
            end
            S_EXP_K: begin
                n_sum = w_sum;
                if (r_k == 4'(EXP_TERMS)) begin
                    if (w_sum < 0) begin
                        n_xres = 31'd0;
                    end else if (w_sum > $signed({3'd0, ONE_Q30[30:0]})) begin
                        n_xres = ONE_Q30[30:0];
                    end else begin
                        n_xres = w_sum[30:0];
                    end
                    n_j = 3'd0;
                    n_state = S_EXP_P;
                end else begin
                    n_k = r_k + 4'd1;
                    w_req.start = 1'b1;
                    w_a = {33'd0, w_term};
                    w_b = {34'd0, r_xf};
                    n_ret = S_EXP_T;
                    n_state = S_WAIT;
                end
            end
            S_EXP_P: begin
                if (r_j == 3'(EXP_BITS)) begin
                    n_state = S_EXP_DONE;
                end else if (r_xn[r_j]) begin
                    w_req.start = 1'b1;
                    w_a = {33'd0, r_xres};
                    w_b = exp_factor(r_j);
                    n_ret = S_EXP_PM;
                    n_state = S_WAIT;
                end else begin
                    n_j = r_j + 3'd1;
                end
            end
            S_EXP_PM: begin
                n_xres = w_res[60:30];
                n_j = r_j + 3'd1;
                n_state = S_EXP_P;
            end
            S_EXP_DONE: begin
                if (!r_xsel) begin
                    n_e1 = r_xres;
                    n_state = S_EULER;
                end else begin
                    n_e2 = r_xres;
                    n_state = S_FIN1;
                end
            end
            S_EULER: begin
                n_up = ({8'd0, r_u} >= r_q10);
                w_req.start = 1'b1;
                w_a = {32'd0, w_diff};
                w_b = {40'd0, r_ts};
                n_ret = S_EUL_D;
                n_state = S_WAIT;
            end
            S_EUL_D: begin
                w_req.start = 1'b1;
                w_req.op = MDU_DIV;
                w_a = w_res[63:0];
                w_b = A1_F;
                n_ret = S_EUL_N;
                n_state = S_WAIT;
            end
            S_EUL_N: begin
                if (r_up) begin
                    w_nh = {41'd0, r_h} + {1'b0, w_delta};
                end else if (w_delta >= {40'd0, r_h}) begin
                    w_nh = 65'd0;
                end else begin
                    w_nh = {41'd0, r_h} - {1'b0, w_delta};
                end
                if (w_nh > {1'b0, H_CAP}) begin
                    n_level = H_CAP[23:0];
                end else begin
                    n_level = w_nh[23:0];
                end
                n_cnt = 5'd0;
                if (r_y == 24'd0) begin
                    n_state = S_FIN1;
                end else begin
                    w_req.start = 1'b1;
                    w_a = {40'd0, r_y};
                    w_b = {40'd0, r_y};
                    n_ret = S_POW;
                    n_state = S_WAIT;
                end
            end
            S_POW: begin
                n_d = w_dn;
                if (r_cnt == 5'(POW_MULS - 1)) begin
                    if (w_dn == 64'd0) begin
                        n_state = S_FIN1;
                    end else begin
                        w_req.start = 1'b1;
                        w_a = CQ;
                        w_b = {40'd0, r_ts};
                        n_ret = S_R2NUM;
                        n_state = S_WAIT;
                    end
                end else begin
                    n_cnt = r_cnt + 5'd1;
                    w_req.start = 1'b1;
                    w_a = w_dn;
                    w_b = {40'd0, r_y};
                    n_ret = S_POW;
                    n_state = S_WAIT;
                end
            end
            S_R2NUM: begin
                w_req.start = 1'b1;
                w_req.op = MDU_DIV;
                w_a = w_res[63:0];
                w_b = r_d;
                n_ret = S_R2;
                n_state = S_WAIT;
            end
            S_R2: begin
                n_xr = w_res[63:0];
                n_xsel = 1'b1;
                n_state = S_EXP_INIT;
            end
            S_FIN1: begin
                w_req.start = 1'b1;
                w_a = {33'd0, w_b10};
                w_b = {33'd0, w_b20};
                n_ret = S_FIN2;
                n_state = S_WAIT;
            end
            S_FIN2: begin
                n_b0 = w_res[61:30];
                w_req.start = 1'b1;
                w_a = {33'd0, r_e1};
                w_b = {33'd0, r_e2};
                n_ret = S_FIN3;
                n_state = S_WAIT;
            end
            S_FIN3: begin
                // hold here while the previous result is still unclaimed
                if (!r_out_valid || !i_out_stall) begin
                    n_ob0   = r_b0;
                    n_oa1   = 32'd0 - ({1'b0, r_e1} + {1'b0, r_e2});
                    n_oa2   = w_res[61:30];
                    n_ofull = r_full;
                    n_out_valid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ret       <= S_IDLE;
            r_ts        <= 24'd6554;
            r_level     <= 24'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ret       <= n_ret;
            r_level     <= n_level;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_ts <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_u <= n_u;       r_y <= n_y;       r_h <= n_h;
        r_srem <= n_srem; r_root <= n_root; r_sbit <= n_sbit; r_cnt <= n_cnt;
        r_q10 <= n_q10;   r_full <= n_full; r_den1 <= n_den1;
        r_e1 <= n_e1;     r_e2 <= n_e2;     r_d <= n_d;       r_up <= n_up;
        r_xsel <= n_xsel; r_xr <= n_xr;     r_xn <= n_xn;     r_xf <= n_xf;
        r_sum <= n_sum;   r_k <= n_k;       r_j <= n_j;       r_xres <= n_xres;
        r_b0 <= n_b0;
        r_ob0 <= n_ob0;   r_oa1 <= n_oa1;   r_oa2 <= n_oa2;   r_ofull <= n_ofull;
    end

    assign o_in_stall    = (r_state != S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_coef_b0     = $signed(r_ob0);
    assign o_coef_a1     = $signed(r_oa1);
    assign o_coef_a2     = $signed(r_oa2);
    assign o_model_delay = r_ofull ? 2'd1 : 2'd2;
    assign o_tank_full   = r_ofull;

endmodule
`default_nettype wire

@@ rtl/core/ttml_chk.sv @@
`default_nettype none
module ttml_chk (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        o_in_stall,
    input wire logic        o_out_valid,
    input wire logic        i_out_stall,
    input wire logic [31:0] o_coef_b0,
    input wire logic [31:0] o_coef_a2,
    input wire logic [1:0]  o_model_delay,
    input wire logic        o_tank_full
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_coef_b0)
            && $stable(o_coef_a2) && $stable(o_tank_full)))
        else $error("stalled result changed");

    a_delay_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_tank_full && o_model_delay == 2'd1)
            || (!o_tank_full && o_model_delay == 2'd2)))
        else $error("delay disagrees with full flag");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not held off after transaction");

    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && !o_out_valid) |=> !o_out_valid)
        else $error("result appeared without computation");

endmodule

bind two_tank_model_linearizer_core ttml_chk u_ttml_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_stall    (o_in_stall),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_coef_b0     (o_coef_b0),
    .o_coef_a2     (o_coef_a2),
    .o_model_delay (o_model_delay),
    .o_tank_full   (o_tank_full)
);
`default_nettype wire
